>>> hdl/tse_pkg.sv
// Shared types, constants and helper functions for the timestamp seal encoder.
// Used by tse_ctrl, tse_datapath and timestamp_seal_encoder; depends on nothing.
`default_nettype none

package tse_pkg;

   // Block geometry and sizes of the internal stores.
   localparam int BLOCK_LEN  = 12;
   localparam int KEY_LEN    = 50;
   localparam int TAIL_DEPTH = 2 * BLOCK_LEN;
   localparam int MAX_DIGITS = 8;

   // Fixed bytes of the seal trailer and of the encoding.
   localparam logic [7:0] SEAL_OPEN  = 8'h18;
   localparam logic [7:0] SEAL_CLOSE = 8'h19;
   localparam logic [7:0] PAD_BYTE   = 8'h31;
   localparam logic [7:0] TRAIL_HI   = 8'h80;
   localparam logic [7:0] TRAIL_LF   = 8'h0a;
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ENC_OFFSET = 8'h20;
   localparam logic [7:0] HIGH_BIT   = 8'h80;

   // Reciprocal of ten scaled by 2^27, rounded up; exact for 24-bit dividends.
   localparam logic [23:0] RECIP_TEN = 24'd13421773;
   localparam int          RECIP_SHIFT = 27;

   // The 50-character key phrase, one ASCII byte per entry.
   localparam logic [7:0] KEY_TABLE [KEY_LEN] = '{
      8'h54, 8'h69, 8'h6D, 8'h65, 8'h73, 8'h74, 8'h61, 8'h6D, 8'h70, 8'h20,
      8'h28, 8'h46, 8'h49, 8'h43, 8'h53, 8'h29, 8'h20, 8'h76, 8'h31, 8'h2E,
      8'h30, 8'h20, 8'h2D, 8'h20, 8'h70, 8'h72, 8'h6F, 8'h67, 8'h72, 8'h61,
      8'h6D, 8'h6D, 8'h65, 8'h64, 8'h20, 8'h62, 8'h79, 8'h20, 8'h48, 8'h65,
      8'h6E, 8'h72, 8'h69, 8'h6B, 8'h20, 8'h47, 8'h72, 8'h61, 8'h6D, 8'h2E
   };

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_COPY,
      ST_CLOSE,
      ST_PAD,
      ST_EMIT_MSG,
      ST_EMIT_SEAL,
      ST_TRAIL_HI,
      ST_TRAIL_LF
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic ld_msg;
      logic ld_seal;
      logic div_step;
      logic copy_step;
      logic close_step;
      logic pad_step;
      logic emit_step;
      logic emit_last;
      logic hi_step;
      logic lf_step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op;
      logic fill_full;
      logic div_done;
      logic copy_last;
      logic pad_done;
      logic emit_last;
      logic out_free;
   } status_type;

   // Position within a block after the three fixed swaps.
   function automatic logic [3:0] swap_pos(input logic [3:0] pos);
      logic [3:0] res;
      unique case (pos)
         4'd0:    res = 4'd11;
         4'd11:   res = 4'd0;
         4'd2:    res = 4'd9;
         4'd9:    res = 4'd2;
         4'd4:    res = 4'd7;
         4'd7:    res = 4'd4;
         default: res = pos;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

>>> hdl/tse_ctrl.sv
// Controller state machine of the timestamp seal encoder.
// Depends on tse_pkg; drives the datapath commands from its status.
`default_nettype none

module tse_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  tse_pkg::status_type   status,
   output tse_pkg::cmd_type      cmd
);
   import tse_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (status.op) begin
                  state_in = ST_DIV;
               end else if (status.fill_full) begin
                  state_in = ST_EMIT_MSG;
               end
            end
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_COPY;
         end
         ST_COPY: begin
            if (status.copy_last) state_in = ST_CLOSE;
         end
         ST_CLOSE: state_in = ST_PAD;
         ST_PAD: begin
            if (status.pad_done) state_in = ST_EMIT_SEAL;
         end
         ST_EMIT_MSG: begin
            if (status.out_free && status.emit_last) state_in = ST_IDLE;
         end
         ST_EMIT_SEAL: begin
            if (status.out_free && status.emit_last) state_in = ST_TRAIL_HI;
         end
         ST_TRAIL_HI: begin
            if (status.out_free) state_in = ST_TRAIL_LF;
         end
         ST_TRAIL_LF: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: handshake and datapath commands.
   always_comb begin
      req_tready     = (state_ff == ST_IDLE);
      cmd            = '0;
      cmd.ld_msg     = (state_ff == ST_IDLE) && req_tvalid && !status.op;
      cmd.ld_seal    = (state_ff == ST_IDLE) && req_tvalid && status.op;
      cmd.div_step   = (state_ff == ST_DIV);
      cmd.copy_step  = (state_ff == ST_COPY);
      cmd.close_step = (state_ff == ST_CLOSE);
      cmd.pad_step   = (state_ff == ST_PAD) && !status.pad_done;
      cmd.emit_step  = ((state_ff == ST_EMIT_MSG) || (state_ff == ST_EMIT_SEAL))
                       && status.out_free;
      cmd.emit_last  = (state_ff == ST_EMIT_MSG) && status.emit_last;
      cmd.hi_step    = (state_ff == ST_TRAIL_HI) && status.out_free;
      cmd.lf_step    = (state_ff == ST_TRAIL_LF) && status.out_free;
   end

endmodule

`default_nettype wire

>>> hdl/tse_datapath.sv
// Datapath of the timestamp seal encoder: byte store, decimal conversion,
// block permutation, key encoding and the output register. Depends on tse_pkg.
`default_nettype none

module tse_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [31:0]      req_tdata,  // byte_value [7:0], timestamp_ms [31:8]
   input  wire logic             req_tuser,  // op [0]
   input  wire logic             rsp_tready,
   output logic                  rsp_tvalid,
   output logic [7:0]            rsp_tdata,  // out_byte [7:0]
   output logic                  rsp_tlast,
   input  tse_pkg::cmd_type      cmd,
   output tse_pkg::status_type   status
);
   import tse_pkg::*;

   logic [7:0]  buf_ff [TAIL_DEPTH];
   logic [3:0]  dig_ff [MAX_DIGITS];
   logic [3:0]  fill_ff, fill_in;
   logic [5:0]  phase_ff, phase_in;
   logic [4:0]  len_ff, len_in;
   logic [4:0]  rd_ff, rd_in;
   logic [23:0] val_ff, val_in;
   logic [3:0]  nd_ff, nd_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic        out_valid_ff, out_valid_in;

   logic        wr_en;
   logic [4:0]  wr_idx;
   logic [7:0]  wr_data;
   logic [47:0] prod;
   logic [23:0] quot;
   logic [23:0] quot_x10;
   logic [3:0]  rem;
   logic [3:0]  top_digit;
   logic        rd_hi;
   logic [3:0]  rd_pos;
   logic [4:0]  rd_idx;
   logic [7:0]  enc_byte;
   logic        out_free;

   // Divide the running value by ten through the scaled reciprocal.
   always_comb begin
      prod     = val_ff * RECIP_TEN;
      quot     = {3'b000, prod[47:RECIP_SHIFT]};
      quot_x10 = (quot << 3) + (quot << 1);
      rem      = 4'(val_ff - quot_x10);
   end

   // Most significant digit still on the digit stack.
   assign top_digit = dig_ff[3'(nd_ff - 4'd1)];

   // Store write port: message bytes, seal open, digits, seal close, padding.
   always_comb begin
      wr_en   = 1'b1;
      wr_idx  = len_ff;
      wr_data = PAD_BYTE;
      priority if (cmd.ld_msg) begin
         wr_idx  = {1'b0, fill_ff};
         wr_data = req_tdata[7:0];
      end else if (cmd.ld_seal) begin
         wr_idx  = {1'b0, fill_ff};
         wr_data = SEAL_OPEN;
      end else if (cmd.copy_step) begin
         wr_data = ASCII_ZERO + {4'b0000, top_digit};
      end else if (cmd.close_step) begin
         wr_data = SEAL_CLOSE;
      end else if (cmd.pad_step) begin
         wr_data = PAD_BYTE;
      end else begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) buf_ff[wr_idx] <= wr_data;
   end

   // Digit stack, least significant digit at the bottom.
   always_ff @(posedge clock) begin
      if (cmd.div_step) dig_ff[nd_ff[2:0]] <= rem;
   end

   // Read side: block base, swapped position, then key encoding.
   always_comb begin
      rd_hi    = (rd_ff >= 5'(BLOCK_LEN));
      rd_pos   = rd_hi ? 4'(rd_ff - 5'(BLOCK_LEN)) : rd_ff[3:0];
      rd_idx   = (rd_hi ? 5'(BLOCK_LEN) : 5'd0) + {1'b0, swap_pos(rd_pos)};
      enc_byte = ((buf_ff[rd_idx] | HIGH_BIT) ^ KEY_TABLE[phase_ff]) - ENC_OFFSET;
   end

   assign out_free = !out_valid_ff || rsp_tready;

   // Counter and value updates.
   always_comb begin
      fill_in  = fill_ff;
      len_in   = len_ff;
      rd_in    = rd_ff;
      phase_in = phase_ff;
      val_in   = val_ff;
      nd_in    = nd_ff;
      if (cmd.ld_msg) begin
         rd_in = 5'd0;
         if (fill_ff == 4'(BLOCK_LEN - 1)) begin
            fill_in = 4'd0;
            len_in  = 5'(BLOCK_LEN);
         end else begin
            fill_in = fill_ff + 4'd1;
         end
      end
      if (cmd.ld_seal) begin
         len_in = {1'b0, fill_ff} + 5'd1;
         rd_in  = 5'd0;
         val_in = req_tdata[31:8];
         nd_in  = 4'd0;
      end
      if (cmd.div_step) begin
         val_in = quot;
         nd_in  = nd_ff + 4'd1;
      end
      if (cmd.copy_step) begin
         nd_in  = nd_ff - 4'd1;
         len_in = len_ff + 5'd1;
      end
      if (cmd.close_step || cmd.pad_step) len_in = len_ff + 5'd1;
      if (cmd.emit_step) begin
         rd_in    = rd_ff + 5'd1;
         phase_in = (phase_ff == 6'(KEY_LEN - 1)) ? 6'd0 : phase_ff + 6'd1;
      end
      if (cmd.lf_step) begin
         fill_in  = 4'd0;
         phase_in = 6'd0;
      end
   end

   // Output register, refilled when empty or being taken.
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit_step || cmd.hi_step || cmd.lf_step) begin
         out_valid_in = 1'b1;
         out_last_in  = cmd.emit_step ? cmd.emit_last : cmd.lf_step;
         priority if (cmd.emit_step) begin
            out_byte_in = enc_byte;
         end else if (cmd.hi_step) begin
            out_byte_in = TRAIL_HI;
         end else begin
            out_byte_in = TRAIL_LF;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= 4'd0;
         phase_ff     <= 6'd0;
         len_ff       <= 5'd0;
         rd_ff        <= 5'd0;
         nd_ff        <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         len_ff       <= len_in;
         rd_ff        <= rd_in;
         nd_ff        <= nd_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      val_ff      <= val_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

   // Status towards the controller.
   always_comb begin
      status.op        = req_tuser;
      status.fill_full = (fill_ff == 4'(BLOCK_LEN - 1));
      status.div_done  = (quot == 24'd0) || (nd_ff == 4'(MAX_DIGITS - 1));
      status.copy_last = (nd_ff == 4'd1);
      status.pad_done  = (len_ff == 5'(BLOCK_LEN)) || (len_ff == 5'(TAIL_DEPTH));
      status.emit_last = (rd_ff == len_ff - 5'd1);
      status.out_free  = out_free;
   end

endmodule

`default_nettype wire

>>> hdl/timestamp_seal_encoder.sv
// Timestamp seal encoder: one item in at a time, one item out per cycle while emitting
// and the output is not stalled. A message byte that does not complete a block gives no output;
// the twelfth byte of a block then gives twelve items, one a cycle unless stalled. A seal makes
// D decimal digits (one divide-by-ten and one copy each), P pad bytes up to the block
// boundary, then E items (12 or 24) and two trailer bytes.
// Synchronous active-high reset clears the counters and the output valid flag.
`default_nettype none

module timestamp_seal_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // byte_value [7:0], timestamp_ms [31:8]
   input  wire logic        req_tuser,   // op [0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_byte [7:0]
   output logic             rsp_tlast
);
   import tse_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   tse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Storage and encoding.
   tse_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

   // A seal always produces output, so input is held off on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("input taken directly after a seal");

   // While waiting for input, only the final item of a run may still be pending.
   assert property (@(posedge clock) disable iff (reset)
      req_tready && rsp_tvalid |-> rsp_tlast)
      else $error("non-final item pending while idle");

   // A byte that does not complete a block leaves the block ready for more.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && !status.fill_full |=> req_tready)
      else $error("partial block byte stalled the input");

endmodule

`default_nettype wire
